@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define SVT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SVT_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/svt_pkg.sv @@
// package for the sorted value table: sizes, operation codes, cell control
`default_nettype none
package svt_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_W     = 5;
   localparam int POS_W       = 5;
   localparam int OP_W        = 2;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 72;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } svt_op_type;

   typedef struct packed {
      logic                          insert_en;
      logic                          remove_en;
      logic                          clear_en;
      logic signed [VALUE_WIDTH-1:0] operand;
   } svt_ctl_type;

endpackage
`default_nettype wire

@@ rtl/sorted_value_table.sv @@
// sorted value table: up to DEPTH signed values in ascending order
//
// req channel carries one operation per word: insert, remove, read at a
// 1-based position, or clear. rsp channel returns one word per request with
// ok, the read value, and the count and largest value after the operation.
// every slot of a chain of cells compares itself against the operand at
// once, so the whole table shifts together when a request is taken.
// the response word is valid the cycle after the request is taken.
// one request per cycle while the receiver takes each response word.
// req_tready is high while the response register is empty or being taken,
// so a stalled receiver holds the response and blocks further requests.
// count and largest are read from the table state, which only changes when
// the next request is taken.
// reset empties the table and drops any pending response; stored values are
// not cleared, only their valid flags.
`default_nettype none
module sorted_value_table (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // op[1:0], value[33:2], position[38:34], zero pad
   input  wire [svt_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // ok[0], read_value[32:1], count[37:33], largest[69:38], zero pad
   output logic [svt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import svt_pkg::*;

   svt_op_type                    op;
   logic signed [VALUE_WIDTH-1:0] operand;
   logic [POS_W-1:0]              position;

   logic                          accept;
   logic                          full;
   logic                          found;
   logic                          ok;
   logic signed [VALUE_WIDTH-1:0] rd_value;
   logic signed [VALUE_WIDTH-1:0] largest;
   svt_ctl_type                   ctl;

   logic [DEPTH-1:0]              cell_valid;
   logic [DEPTH-1:0]              cell_lt;
   logic [DEPTH-1:0]              cell_hit;
   logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]              rd_sel;
   logic [DEPTH-1:0]              top_sel;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          ok_ff, ok_in;
   logic signed [VALUE_WIDTH-1:0] rd_value_ff, rd_value_in;
   logic [COUNT_W-1:0]            count_ff, count_in;

   assign op       = svt_op_type'(req_tdata[OP_W-1:0]);
   assign operand  = req_tdata[OP_W+VALUE_WIDTH-1:OP_W];
   assign position = req_tdata[OP_W+VALUE_WIDTH+POS_W-1:OP_W+VALUE_WIDTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign found      = |cell_hit;

   assign ctl.insert_en = accept && (op == OP_INSERT) && !full;
   assign ctl.remove_en = accept && (op == OP_REMOVE) && found;
   assign ctl.clear_en  = accept && (op == OP_CLEAR);
   assign ctl.operand   = operand;

   // chain ends: slot 0 sees a lower neighbor below everything, the last
   // slot sees an empty neighbor on its right
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      svt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_lt     ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i-1]),
         .left_valid  ((i == 0) ? 1'b0 : cell_valid[(i == 0) ? 0 : i-1]),
         .left_value  ((i == 0) ? '0 : cell_value[(i == 0) ? 0 : i-1]),
         .right_valid ((i == DEPTH - 1) ? 1'b0 : cell_valid[(i == DEPTH - 1) ? i : i+1]),
         .right_value ((i == DEPTH - 1) ? '0 : cell_value[(i == DEPTH - 1) ? i : i+1]),
         .valid       (cell_valid[i]),
         .value       (cell_value[i]),
         .lt          (cell_lt[i]),
         .hit         (cell_hit[i])
      );
      assign rd_sel[i]  = cell_valid[i] && (position == POS_W'(i + 1));
      assign top_sel[i] = cell_valid[i] &&
                          ((i == DEPTH - 1) ? 1'b1 : !cell_valid[(i == DEPTH - 1) ? i : i+1]);
   end

   // one-hot pick of the read slot and of the highest occupied slot
   always_comb begin
      rd_value = '0;
      largest  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_value = rd_value | (rd_sel[i]  ? cell_value[i] : '0);
         largest  = largest  | (top_sel[i] ? cell_value[i] : '0);
      end
   end

   always_comb begin
      ok       = 1'b0;
      count_in = count_ff;
      case (op)
         OP_INSERT: begin
            ok = !full;
            if (!full) count_in = count_ff + COUNT_W'(1);
         end
         OP_REMOVE: begin
            ok = found;
            if (found) count_in = count_ff - COUNT_W'(1);
         end
         OP_READ: begin
            ok = |rd_sel;
         end
         OP_CLEAR: begin
            ok       = (count_ff != '0);
            count_in = '0;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (!accept) count_in = count_ff;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   assign ok_in        = accept ? ok : ok_ff;
   assign rd_value_in  = accept ? ((op == OP_READ) ? rd_value : '0) : rd_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      ok_ff       <= ok_in;
      rd_value_ff <= rd_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 1 - 2*VALUE_WIDTH - COUNT_W){1'b0}},
                        largest, count_ff, rd_value_ff, ok_ff};

endmodule
`default_nettype wire

@@ rtl/svt_cell.sv @@
// one slot of the sorted chain: holds a value and moves it left or right
`default_nettype none
module svt_cell (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire svt_pkg::svt_ctl_type            ctl,
   input  wire                                  left_lt,
   input  wire                                  left_valid,
   input  wire signed [svt_pkg::VALUE_WIDTH-1:0] left_value,
   input  wire                                  right_valid,
   input  wire signed [svt_pkg::VALUE_WIDTH-1:0] right_value,
   output logic                                 valid,
   output logic signed [svt_pkg::VALUE_WIDTH-1:0] value,
   output logic                                 lt,
   output logic                                 hit
);
   import svt_pkg::*;

   logic                          valid_ff, valid_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;

   assign valid = valid_ff;
   assign value = value_ff;
   assign lt    = valid_ff && (value_ff < ctl.operand);
   assign hit   = valid_ff && (value_ff == ctl.operand);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.clear_en) begin
         valid_in = 1'b0;
      end else if (ctl.insert_en && !lt) begin
         // first slot not below the operand takes it, the rest move right
         if (left_lt) begin
            valid_in = 1'b1;
            value_in = ctl.operand;
         end else begin
            valid_in = left_valid;
            value_in = left_value;
         end
      end else if (ctl.remove_en && !lt) begin
         valid_in = right_valid;
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

@@ rtl/svt_checker.sv @@
// port-level checker for the sorted value table, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module svt_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [svt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import svt_pkg::*;

   logic                   rsp_ok;
   logic [VALUE_WIDTH-1:0] rsp_rd;
   logic [COUNT_W-1:0]     rsp_count;
   logic [VALUE_WIDTH-1:0] rsp_largest;
   logic                   req_take;

   assign rsp_ok      = rsp_tdata[0];
   assign rsp_rd      = rsp_tdata[VALUE_WIDTH:1];
   assign rsp_count   = rsp_tdata[VALUE_WIDTH+COUNT_W:VALUE_WIDTH+1];
   assign rsp_largest = rsp_tdata[2*VALUE_WIDTH+COUNT_W:VALUE_WIDTH+COUNT_W+1];
   assign req_take    = req_tvalid && req_tready;

   `SVT_ASSERT_RST(a_reset_idle, clock, reset |=> !rsp_tvalid, "response valid after reset")

   `SVT_ASSERT(a_rsp_follows_req, clock, reset, req_take |=> rsp_tvalid,
      "no response after an accepted request")

   `SVT_ASSERT(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled word changed")

   `SVT_ASSERT(a_empty_largest, clock, reset,
      (rsp_tvalid && (rsp_count == '0)) |-> (rsp_largest == '0), "largest not zero when empty")

   `SVT_ASSERT(a_read_needs_ok, clock, reset,
      (rsp_tvalid && (rsp_rd != '0)) |-> rsp_ok, "read value without ok")

endmodule

bind sorted_value_table svt_checker u_svt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ dv/sorted_value_table_tb.sv @@
`timescale 1ns / 100ps
// testbench for sorted_value_table: ordered insert, remove, read and clear under random stalls
module sorted_value_table_tb;
   import svt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_GAP     = 18;
   localparam int HOLD_CYCLES = 150;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct {
      logic               ok;
      value_type          read_value;
      logic [COUNT_W-1:0] count;
      value_type          largest;
   } table_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // op[1:0], value[33:2], position[38:34], zero pad
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // ok[0], read_value[32:1], count[37:33], largest[69:38], zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the table, ascending in slots 0..table_count-1
   value_type        table_vals [DEPTH];
   int               table_count  = 0;
   table_result_type expected_results [$];
   int               error_count  = 0;
   int               cycle_count  = 0;
   bit               idle_on      = 1'b1;
   int               hold_request = 0;
   int               rsp_hold     = 0;
   int               rsp_gap      = 0;

   sorted_value_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, MAX_GAP) : 0;
   endfunction

   function automatic value_type pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      // a narrow pool makes duplicates and successful removes common
      if (roll < 3) return $urandom_range(0, 8) - 4;
      if (roll == 3) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0001;
            default: return 32'h7fff_fffe;
         endcase
      end
      return $urandom();
   endfunction

   // applies one operation to the shadow table and returns the word it yields
   function automatic table_result_type table_apply(input svt_op_type op,
                                                    input value_type value,
                                                    input logic [POS_W-1:0] pos);
      table_result_type r;
      int               k;
      int               i;
      r.ok         = 1'b0;
      r.read_value = '0;
      k            = 0;
      case (op)
         OP_INSERT: begin
            if (table_count < DEPTH) begin
               while (k < table_count && table_vals[k] < value) k++;
               for (i = table_count; i > k; i--) table_vals[i] = table_vals[i-1];
               table_vals[k] = value;
               table_count++;
               r.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            while (k < table_count && table_vals[k] < value) k++;
            if (k < table_count && table_vals[k] == value) begin
               for (i = k; i + 1 < table_count; i++) table_vals[i] = table_vals[i+1];
               table_count--;
               r.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (pos >= 1 && pos <= table_count) begin
               r.read_value = table_vals[pos-1];
               r.ok         = 1'b1;
            end
         end
         default: begin
            r.ok        = (table_count != 0);
            table_count = 0;
         end
      endcase
      r.count   = COUNT_W'(table_count);
      r.largest = (table_count > 0) ? table_vals[table_count-1] : '0;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [RSP_DATA_W-1:0] got,
                                  input logic [RSP_DATA_W-1:0] want);
      $display("cycle %0d: mismatch on %s: got %0h, expected %0h", cycle_count, field, got,
               want);
      error_count++;
   endtask

   // valid stays high across back-to-back words; it only drops before a gap
   task automatic send_word(input svt_op_type op, input value_type value,
                            input logic [POS_W-1:0] pos);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {1'b0, pos, value, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(table_apply(op, value, pos));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // response side: check each word, then pick the next stall
   always @(posedge clock) begin : rsp_side
      table_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.ok)
                  report_mismatch("ok", RSP_DATA_W'(rsp_tdata[0]), RSP_DATA_W'(want.ok));
               if (rsp_tdata[32:1] !== want.read_value)
                  report_mismatch("read_value", RSP_DATA_W'(rsp_tdata[32:1]),
                                  RSP_DATA_W'(want.read_value));
               if (rsp_tdata[37:33] !== want.count)
                  report_mismatch("count", RSP_DATA_W'(rsp_tdata[37:33]),
                                  RSP_DATA_W'(want.count));
               if (rsp_tdata[69:38] !== want.largest)
                  report_mismatch("largest", RSP_DATA_W'(rsp_tdata[69:38]),
                                  RSP_DATA_W'(want.largest));
            end
            rsp_gap = draw_gap();
         end
         if (hold_request != 0) begin
            rsp_hold = hold_request;
            hold_request <= 0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_empty_table();
      send_word(OP_CLEAR, 0, 0);
      send_word(OP_REMOVE, 0, 0);
      send_word(OP_READ, 0, 0);
      send_word(OP_READ, 0, 16);
      wait_idle();
   endtask

   task automatic test_extremes();
      send_word(OP_INSERT, 32'h8000_0000, 0);
      send_word(OP_INSERT, 32'h7fff_ffff, 0);
      send_word(OP_INSERT, -1, 0);
      // duplicate of the largest value
      send_word(OP_INSERT, 32'h7fff_ffff, 0);
      send_word(OP_READ, 0, 1);
      send_word(OP_READ, 0, 4);
      send_word(OP_READ, 0, 5);
      send_word(OP_REMOVE, 5, 0);
      send_word(OP_REMOVE, 32'h7fff_ffff, 0);
      send_word(OP_REMOVE, 32'h8000_0000, 0);
      wait_idle();
   endtask

   task automatic test_full_table();
      // descending inserts each shift every value above them right, until the table is full
      for (int i = 0; i < DEPTH; i++) send_word(OP_INSERT, 1000 - i * 7, 0);
      send_word(OP_INSERT, 42, 0);
      send_word(OP_READ, 0, 16);
      send_word(OP_CLEAR, 0, 0);
      wait_idle();
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_request <= HOLD_CYCLES;
      for (int i = 0; i < 40; i++)
         send_word(OP_INSERT, pick_value(), POS_W'($urandom_range(0, DEPTH)));
      wait_idle();
      idle_on = 1'b1;
   endtask

   task automatic test_random_mix(input int n_items);
      svt_op_type       op;
      value_type        value;
      logic [POS_W-1:0] pos;
      bit               filling;
      int               roll;
      filling = 1'b1;
      for (int n = 0; n < n_items; n++) begin
         if (n % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
         // swing between full and empty so both ends are reached often
         if (table_count == DEPTH) filling = 1'b0;
         else if (table_count == 0) filling = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 2) op = OP_CLEAR;
         else if (roll < 22) op = OP_READ;
         else if (roll < (filling ? 80 : 37)) op = OP_INSERT;
         else op = OP_REMOVE;
         value = pick_value();
         pos   = POS_W'($urandom_range(0, DEPTH));
         if (op == OP_REMOVE && table_count > 0 && $urandom_range(0, 3) != 0)
            value = table_vals[$urandom_range(0, table_count - 1)];
         if (op == OP_READ && table_count > 0 && $urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(1, table_count));
         send_word(op, value, pos);
      end
      wait_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_extremes();
      test_full_table();
      test_backpressure();
      test_random_mix(800);
      repeat (4) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
